>>> hw/rtl/esd_pkg.sv
package esd_pkg;

  // Position counters inside the decoder; reported positions are 16 bits
  localparam int POS_BITS = 16;

  // Results one input beat can cause, and the result queue depth
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_BITS = $clog2(MAX_RESULTS);
  localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_SLICE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_UNCLOSED_BRACE = 3'd0;
  localparam logic [2:0] ERR_TRAILING_BSL   = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN_ESC    = 3'd2;
  localparam logic [2:0] ERR_BAD_NUMBER     = 3'd3;
  localparam logic [2:0] ERR_OCTAL_RANGE    = 3'd4;

  // Number kinds
  localparam logic [1:0] NUM_OCT = 2'd0;
  localparam logic [1:0] NUM_X   = 2'd1;
  localparam logic [1:0] NUM_U   = 2'd2;

  // Character codes
  localparam logic [15:0] CH_0      = 16'h0030;
  localparam logic [15:0] CH_7      = 16'h0037;
  localparam logic [15:0] CH_9      = 16'h0039;
  localparam logic [15:0] CH_A_UP   = 16'h0041;
  localparam logic [15:0] CH_F_UP   = 16'h0046;
  localparam logic [15:0] CH_A_LO   = 16'h0061;
  localparam logic [15:0] CH_F_LO   = 16'h0066;
  localparam logic [15:0] CH_T      = 16'h0074;
  localparam logic [15:0] CH_N      = 16'h006E;
  localparam logic [15:0] CH_R      = 16'h0072;
  localparam logic [15:0] CH_X_LO   = 16'h0078;
  localparam logic [15:0] CH_X_UP   = 16'h0058;
  localparam logic [15:0] CH_U_LO   = 16'h0075;
  localparam logic [15:0] CH_U_UP   = 16'h0055;
  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_APOS   = 16'h0027;
  localparam logic [15:0] CH_LBRACE = 16'h007B;
  localparam logic [15:0] CH_RBRACE = 16'h007D;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_TAB    = 16'h0009;
  localparam logic [15:0] CH_LF     = 16'h000A;
  localparam logic [15:0] CH_CR     = 16'h000D;
  localparam logic [15:0] OCT_LIMIT = 16'h00FF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_char;
    logic [15:0] slice_start;
    logic [15:0] slice_length;
    logic [2:0]  error_code;
  } result_t;

  // All results caused by one input beat
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [RES_CNT_BITS-1:0]   count;
  } bundle_t;

  function automatic result_t mk_char(logic [15:0] c);
    result_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.out_char = c;
    return r;
  endfunction

  function automatic result_t mk_slice(logic [15:0] st, logic [15:0] len);
    result_t r;
    r = '0;
    r.kind = KIND_SLICE;
    r.slice_start = st;
    r.slice_length = len;
    return r;
  endfunction

  function automatic result_t mk_error(logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic result_t mk_done();
    result_t r;
    r = '0;
    r.kind = KIND_DONE;
    return r;
  endfunction

  // Digit value of c for the given number kind: {valid, value}
  function automatic logic [4:0] digit_of(logic [15:0] c, logic [1:0] kind);
    logic [4:0] d;
    d = '0;
    if (kind == NUM_OCT) begin
      if (c >= CH_0 && c <= CH_7) d = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_0 && c <= CH_9) begin
      d = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      d = {1'b1, 4'(c - CH_A_LO + 16'd10)};
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      d = {1'b1, 4'(c - CH_A_UP + 16'd10)};
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/esd_in_if.sv
interface esd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

>>> hw/rtl/esd_out_if.sv
interface esd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] out_char;
  logic [15:0] slice_start;
  logic [15:0] slice_length;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output kind, output out_char, output slice_start,
                  output slice_length, output error_code, output last, input ready);
  modport sink (input valid, input kind, input out_char, input slice_start,
                input slice_length, input error_code, input last, output ready);
endinterface

>>> hw/rtl/esd_cfg_if.sv
interface esd_cfg_if;
  logic valid;
  logic ready;
  logic interpolation_enable;

  modport source (output valid, output interpolation_enable, input ready);
  modport sink (input valid, input interpolation_enable, output ready);
endinterface

>>> hw/rtl/esd_front.sv
module esd_front (
  input  logic             clk,
  input  logic             rst,
  esd_in_if.sink           chars,
  esd_cfg_if.sink          cfg,
  output esd_pkg::bundle_t bundle,
  output logic             bundle_valid,
  input  logic             bundle_ready
);
  import esd_pkg::*;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESCAPE = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_BRACE  = 3'd3;
  localparam logic [2:0] MODE_ERROR  = 3'd4;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic                interpolation_enable;
  logic [2:0]          mode, mode_next;
  logic [1:0]          number_kind, number_kind_next;
  logic [2:0]          digit_count, digit_count_next;
  logic [15:0]         number_value, number_value_next;
  logic [POS_BITS-1:0] out_position, out_position_next;
  logic [POS_BITS-1:0] brace_start, brace_start_next;
  logic [POS_BITS-1:0] brace_length, brace_length_next;

  result_t [MAX_RESULTS-1:0] res;
  logic [RES_CNT_BITS-1:0]   cnt;
  logic [15:0]               c;
  logic [4:0]                dig;
  logic [2:0]                max_digits;
  logic                      do_normal;
  logic                      finish;
  logic                      resume;
  logic                      accept;

  assign cfg.ready = 1'b1;
  assign chars.ready = bundle_ready;
  assign accept = chars.valid && chars.ready;

  // Interpolation switch
  always_ff @(posedge clk) begin
    if (rst) begin
      interpolation_enable <= 1'b0;
    end else if (cfg.valid) begin
      interpolation_enable <= cfg.interpolation_enable;
    end
  end

  // Decode one beat: results in order, then the next stream state
  always_comb begin
    c = chars.char_code;
    dig = digit_of(c, number_kind);
    max_digits = (number_kind == NUM_OCT) ? 3'd3 : ((number_kind == NUM_X) ? 3'd2 : 3'd4);
    mode_next = mode;
    number_kind_next = number_kind;
    digit_count_next = digit_count;
    number_value_next = number_value;
    out_position_next = out_position;
    brace_start_next = brace_start;
    brace_length_next = brace_length;
    res = '0;
    cnt = '0;
    do_normal = 1'b0;
    finish = 1'b0;
    resume = 1'b0;

    case (mode)
      MODE_NORMAL: begin
        do_normal = 1'b1;
      end
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        case (c)
          CH_T, CH_N, CH_R, CH_QUOTE, CH_APOS, CH_LBRACE, CH_BSLASH: begin
            if (c == CH_T) begin
              res[cnt[RES_IDX_BITS-1:0]] = mk_char(CH_TAB);
            end else if (c == CH_N) begin
              res[cnt[RES_IDX_BITS-1:0]] = mk_char(CH_LF);
            end else if (c == CH_R) begin
              res[cnt[RES_IDX_BITS-1:0]] = mk_char(CH_CR);
            end else begin
              res[cnt[RES_IDX_BITS-1:0]] = mk_char(c);
            end
            cnt = cnt + 1'b1;
            if (out_position_next != POS_MAX) out_position_next = out_position_next + 1'b1;
          end
          CH_X_LO, CH_X_UP: begin
            mode_next = MODE_NUMBER;
            number_kind_next = NUM_X;
            digit_count_next = 3'd0;
            number_value_next = 16'd0;
          end
          CH_U_LO, CH_U_UP: begin
            mode_next = MODE_NUMBER;
            number_kind_next = NUM_U;
            digit_count_next = 3'd0;
            number_value_next = 16'd0;
          end
          default: begin
            if (c >= CH_0 && c <= CH_7) begin
              mode_next = MODE_NUMBER;
              number_kind_next = NUM_OCT;
              digit_count_next = 3'd1;
              number_value_next = c - CH_0;
            end else begin
              res[cnt[RES_IDX_BITS-1:0]] = mk_error(ERR_UNKNOWN_ESC);
              cnt = cnt + 1'b1;
              mode_next = MODE_ERROR;
            end
          end
        endcase
      end
      MODE_NUMBER: begin
        if (dig[4]) begin
          // Accumulate the digit; a full number closes at once
          if (number_kind == NUM_OCT) begin
            number_value_next = {number_value[12:0], 3'b000} | {12'd0, dig[3:0]};
          end else begin
            number_value_next = {number_value[11:0], dig[3:0]};
          end
          digit_count_next = digit_count + 3'd1;
          finish = (digit_count_next >= max_digits);
        end else if (digit_count == 3'd0) begin
          res[cnt[RES_IDX_BITS-1:0]] = mk_error(ERR_BAD_NUMBER);
          cnt = cnt + 1'b1;
          mode_next = MODE_ERROR;
        end else begin
          finish = 1'b1;
          resume = 1'b1;
        end
        if (finish) begin
          if (number_kind == NUM_OCT && number_value_next > OCT_LIMIT) begin
            res[cnt[RES_IDX_BITS-1:0]] = mk_error(ERR_OCTAL_RANGE);
            cnt = cnt + 1'b1;
            mode_next = MODE_ERROR;
          end else begin
            res[cnt[RES_IDX_BITS-1:0]] = mk_char(number_value_next);
            cnt = cnt + 1'b1;
            if (out_position_next != POS_MAX) out_position_next = out_position_next + 1'b1;
            mode_next = MODE_NORMAL;
            digit_count_next = 3'd0;
            number_value_next = 16'd0;
          end
        end
        // The character that ended the number is decoded as plain text
        if (resume && mode_next == MODE_NORMAL) do_normal = 1'b1;
      end
      MODE_BRACE: begin
        res[cnt[RES_IDX_BITS-1:0]] = mk_char(c);
        cnt = cnt + 1'b1;
        if (out_position_next != POS_MAX) out_position_next = out_position_next + 1'b1;
        if (brace_length != POS_MAX) brace_length_next = brace_length + 1'b1;
        if (c == CH_RBRACE) begin
          res[cnt[RES_IDX_BITS-1:0]] = mk_slice(16'(brace_start), 16'(brace_length_next));
          cnt = cnt + 1'b1;
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
      end
    endcase

    // Plain character handling
    if (do_normal) begin
      if (c == CH_LBRACE && interpolation_enable) begin
        brace_start_next = out_position_next;
        brace_length_next = POS_BITS'(1);
        res[cnt[RES_IDX_BITS-1:0]] = mk_char(c);
        cnt = cnt + 1'b1;
        if (out_position_next != POS_MAX) out_position_next = out_position_next + 1'b1;
        mode_next = MODE_BRACE;
      end else if (c == CH_BSLASH) begin
        mode_next = MODE_ESCAPE;
      end else begin
        res[cnt[RES_IDX_BITS-1:0]] = mk_char(c);
        cnt = cnt + 1'b1;
        if (out_position_next != POS_MAX) out_position_next = out_position_next + 1'b1;
      end
    end

    // Close the string: report what is left open, then done
    if (chars.end_of_string) begin
      if (mode_next == MODE_ESCAPE) begin
        res[cnt[RES_IDX_BITS-1:0]] = mk_error(ERR_TRAILING_BSL);
        cnt = cnt + 1'b1;
      end else if (mode_next == MODE_NUMBER) begin
        res[cnt[RES_IDX_BITS-1:0]] = mk_error(ERR_BAD_NUMBER);
        cnt = cnt + 1'b1;
      end else if (mode_next == MODE_BRACE) begin
        res[cnt[RES_IDX_BITS-1:0]] = mk_error(ERR_UNCLOSED_BRACE);
        cnt = cnt + 1'b1;
      end
      res[cnt[RES_IDX_BITS-1:0]] = mk_done();
      cnt = cnt + 1'b1;
      mode_next = MODE_NORMAL;
      number_kind_next = NUM_OCT;
      digit_count_next = 3'd0;
      number_value_next = 16'd0;
      out_position_next = '0;
      brace_start_next = '0;
      brace_length_next = '0;
    end
  end

  assign bundle.res = res;
  assign bundle.count = cnt;
  assign bundle_valid = accept && (cnt != '0);

  // Advance the stream state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      number_kind <= NUM_OCT;
      digit_count <= 3'd0;
      number_value <= 16'd0;
      out_position <= '0;
      brace_start <= '0;
      brace_length <= '0;
    end else if (accept) begin
      mode <= mode_next;
      number_kind <= number_kind_next;
      digit_count <= digit_count_next;
      number_value <= number_value_next;
      out_position <= out_position_next;
      brace_start <= brace_start_next;
      brace_length <= brace_length_next;
    end
  end

endmodule

>>> hw/rtl/esd_queue.sv
module esd_queue (
  input  logic             clk,
  input  logic             rst,
  input  esd_pkg::bundle_t push_data,
  input  logic             push,
  output logic             not_full,
  output esd_pkg::bundle_t head,
  output logic             not_empty,
  input  logic             pop
);
  import esd_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  bundle_t             entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;

  assign not_full = (fill != CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head = entries[rd_ptr];

  // Store pushed bundles
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // Move pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/esd_back.sv
module esd_back (
  input  logic             clk,
  input  logic             rst,
  input  esd_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  esd_out_if.source        results
);
  import esd_pkg::*;

  logic [RES_IDX_BITS-1:0] idx;
  logic                    is_last;
  result_t                 cur;

  assign cur = head.res[idx];
  assign is_last = (idx == RES_IDX_BITS'(head.count - 1'b1));

  assign results.valid = head_valid;
  assign results.kind = cur.kind;
  assign results.out_char = cur.out_char;
  assign results.slice_start = cur.slice_start;
  assign results.slice_length = cur.slice_length;
  assign results.error_code = cur.error_code;
  assign results.last = is_last;

  // Drop the bundle once its final result has gone out
  assign pop = results.valid && results.ready && is_last;

  // Step through the results of the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (results.valid && results.ready) begin
      if (is_last) begin
        idx <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/escape_sequence_decoder.sv
// Escape sequence decoder: takes a string literal one 16-bit code unit per beat and returns
// decoded characters, interpolation slice records, errors and a done marker, one result per
// output beat, with last set on the final result of each input beat. The front end decodes
// one code unit per clock and files its results, up to four, as one bundle in a four-entry
// queue; the back end sends them out one per clock while results.ready is high. A unit with
// at most one result thus flows at one per cycle; input stalls only while the queue is full.
// The user must write the interpolation_enable register through the cfg channel, which is
// always ready, only while the decoder is idle; the block does not enforce this.
module escape_sequence_decoder (
  input  logic      clk,
  input  logic      rst,
  esd_in_if.sink    chars,
  esd_out_if.source results,
  esd_cfg_if.sink   cfg
);
  import esd_pkg::*;

  bundle_t push_data;
  bundle_t head;
  logic    push;
  logic    not_full;
  logic    not_empty;
  logic    pop;

  // Decode and classify
  esd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .chars        (chars),
    .cfg          (cfg),
    .bundle       (push_data),
    .bundle_valid (push),
    .bundle_ready (not_full)
  );

  // Hold bundles between the two sides
  esd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_data (push_data),
    .push      (push),
    .not_full  (not_full),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop)
  );

  // Send results out one beat at a time
  esd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .results    (results)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

import esd_pkg::*;

// Decoder states as the scoreboard tracks them
typedef enum logic [2:0] {
  ST_NORMAL,
  ST_ESCAPE,
  ST_NUMBER,
  ST_BRACE,
  ST_ERROR
} dec_mode_e;

// One expected output beat
typedef struct packed {
  result_t res;
  logic    last;
} result_beat_t;

class decode_scoreboard;
  bit           interp;
  dec_mode_e    mode;
  logic [1:0]   num_kind;
  int unsigned  digits;
  logic [15:0]  num_val;
  logic [15:0]  out_pos;
  logic [15:0]  br_start;
  logic [15:0]  br_len;
  result_t      step_q[$];
  result_beat_t decoded_q[$];
  int unsigned  fails;

  function new();
    interp = 1'b0;
    fails = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    mode = ST_NORMAL;
    num_kind = NUM_OCT;
    digits = 0;
    num_val = '0;
    out_pos = '0;
    br_start = '0;
    br_len = '0;
  endfunction

  // Queue one result for the current input beat, four at most
  function void add(logic [1:0] k, logic [15:0] ch, logic [15:0] st, logic [15:0] len,
                    logic [2:0] err);
    result_t r;
    if (step_q.size() >= MAX_RESULTS) return;
    r.kind = k;
    r.out_char = ch;
    r.slice_start = st;
    r.slice_length = len;
    r.error_code = err;
    step_q.push_back(r);
  endfunction

  function void put_char(logic [15:0] c);
    add(KIND_CHAR, c, '0, '0, '0);
    if (out_pos != 16'hFFFF) out_pos++;
  endfunction

  function void raise(logic [2:0] code);
    add(KIND_ERROR, '0, '0, '0, code);
    mode = ST_ERROR;
  endfunction

  function int digit_val(logic [15:0] c, logic [1:0] k);
    if (k == NUM_OCT) return (c >= CH_0 && c <= CH_7) ? int'(c - CH_0) : -1;
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_A_LO && c <= CH_F_LO) return int'(c - CH_A_LO) + 10;
    if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + 10;
    return -1;
  endfunction

  function void start_num(logic [1:0] k, int unsigned cnt, logic [15:0] val);
    mode = ST_NUMBER;
    num_kind = k;
    digits = cnt;
    num_val = val;
  endfunction

  function void close_number();
    if (num_kind == NUM_OCT && num_val > OCT_LIMIT) begin
      raise(ERR_OCTAL_RANGE);
      return;
    end
    put_char(num_val);
    mode = ST_NORMAL;
    digits = 0;
    num_val = '0;
  endfunction

  function void on_normal(logic [15:0] c);
    if (c == CH_LBRACE && interp) begin
      br_start = out_pos;
      br_len = 16'd1;
      put_char(c);
      mode = ST_BRACE;
    end else if (c == CH_BSLASH) begin
      mode = ST_ESCAPE;
    end else begin
      put_char(c);
    end
  endfunction

  function void on_escape(logic [15:0] c);
    mode = ST_NORMAL;
    case (c)
      CH_T: put_char(CH_TAB);
      CH_N: put_char(CH_LF);
      CH_R: put_char(CH_CR);
      CH_QUOTE, CH_APOS, CH_LBRACE, CH_BSLASH: put_char(c);
      CH_X_LO, CH_X_UP: start_num(NUM_X, 0, '0);
      CH_U_LO, CH_U_UP: start_num(NUM_U, 0, '0);
      default: begin
        if (c >= CH_0 && c <= CH_7) start_num(NUM_OCT, 1, c - CH_0);
        else raise(ERR_UNKNOWN_ESC);
      end
    endcase
  endfunction

  function void on_number(logic [15:0] c);
    int d;
    int unsigned max_digits;
    int unsigned radix;
    d = digit_val(c, num_kind);
    max_digits = (num_kind == NUM_OCT) ? 3 : ((num_kind == NUM_X) ? 2 : 4);
    radix = (num_kind == NUM_OCT) ? 8 : 16;
    if (d >= 0) begin
      num_val = 16'(num_val * radix + int'(d));
      digits++;
      if (digits >= max_digits) close_number();
      return;
    end
    if (digits == 0) begin
      raise(ERR_BAD_NUMBER);
      return;
    end
    // A character that ends a number is handled as an ordinary one
    close_number();
    if (mode == ST_NORMAL) on_normal(c);
  endfunction

  // Note one accepted code unit; returns 1 when the decoder just drops it
  function bit note_input(logic [15:0] c, logic eos);
    bit dropped;
    result_beat_t b;
    dropped = (mode == ST_ERROR) && !eos;
    step_q.delete();
    case (mode)
      ST_NORMAL: on_normal(c);
      ST_ESCAPE: on_escape(c);
      ST_NUMBER: on_number(c);
      ST_BRACE: begin
        put_char(c);
        if (br_len != 16'hFFFF) br_len++;
        if (c == CH_RBRACE) begin
          add(KIND_SLICE, '0, br_start, br_len, '0);
          mode = ST_NORMAL;
        end
      end
      default: ;
    endcase
    // Close off whatever is still open at the end of the literal
    if (eos) begin
      if (mode == ST_ESCAPE) raise(ERR_TRAILING_BSL);
      else if (mode == ST_NUMBER) raise(ERR_BAD_NUMBER);
      else if (mode == ST_BRACE) raise(ERR_UNCLOSED_BRACE);
      add(KIND_DONE, '0, '0, '0, '0);
      clear_stream();
    end
    foreach (step_q[i]) begin
      b.res = step_q[i];
      b.last = (i == step_q.size() - 1);
      decoded_q.push_back(b);
    end
    return dropped;
  endfunction

  function void check_result(result_t got, logic got_last);
    result_beat_t want;
    if (decoded_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("result with nothing pending: kind=%0d char=%h start=%0d len=%0d err=%0d",
                 got.kind, got.out_char, got.slice_start, got.slice_length, got.error_code);
      return;
    end
    want = decoded_q.pop_front();
    if (got.kind !== want.res.kind || got.out_char !== want.res.out_char ||
        got.slice_start !== want.res.slice_start ||
        got.slice_length !== want.res.slice_length ||
        got.error_code !== want.res.error_code || got_last !== want.last) begin
      fails++;
      if (fails <= 10) begin
        $display("mismatch: expected kind=%0d char=%h start=%0d len=%0d err=%0d last=%0b",
                 want.res.kind, want.res.out_char, want.res.slice_start,
                 want.res.slice_length, want.res.error_code, want.last);
        $display("          got      kind=%0d char=%h start=%0d len=%0d err=%0d last=%0b",
                 got.kind, got.out_char, got.slice_start, got.slice_length,
                 got.error_code, got_last);
      end
    end
  endfunction

  function int unsigned outstanding();
    return decoded_q.size();
  endfunction
endclass

module tb;
  localparam int          RANDOM_ITEMS   = 460;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          TAIL_CYCLES    = 10;
  localparam logic [15:0] CH_G_LO        = 16'h0067;
  localparam logic [15:0] CH_G_UP        = 16'h0047;
  localparam logic [15:0] CH_Q_LO        = 16'h0071;

  logic              clk;
  logic              rst;
  bit                calm;
  int unsigned       accepted_items;
  int unsigned       idle_cycles;
  logic [15:0]       unit_q[$];
  decode_scoreboard  sb;

  esd_in_if  chars_if();
  esd_out_if res_if();
  esd_cfg_if cfg_if();

  escape_sequence_decoder dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .results(res_if),
    .cfg(cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none while calm
  function int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [15:0] plain_char();
    logic [15:0] c;
    c = 16'h0020 + 16'($urandom_range(0, 94));
    if (c == CH_BSLASH || c == CH_LBRACE) c = CH_A_LO;
    return c;
  endfunction

  function logic [15:0] hex_digit();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_0 + 16'(r);
    if (r < 16) return CH_A_LO + 16'(r - 10);
    return CH_A_UP + 16'(r - 16);
  endfunction

  // Append one lexical piece of a literal, mostly well formed
  function void add_token();
    int          pick;
    int          n;
    logic [15:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      unit_q.push_back(plain_char());
    end else if (pick < 40) begin
      unit_q.push_back(16'($urandom));
    end else if (pick < 55) begin
      case ($urandom_range(0, 6))
        0: c = CH_T;
        1: c = CH_N;
        2: c = CH_R;
        3: c = CH_QUOTE;
        4: c = CH_APOS;
        5: c = CH_LBRACE;
        default: c = CH_BSLASH;
      endcase
      unit_q.push_back(CH_BSLASH);
      unit_q.push_back(c);
    end else if (pick < 64) begin
      n = $urandom_range(1, 3);
      unit_q.push_back(CH_BSLASH);
      repeat (n) unit_q.push_back(CH_0 + 16'($urandom_range(0, 7)));
    end else if (pick < 80) begin
      unit_q.push_back(CH_BSLASH);
      if (pick < 72) begin
        unit_q.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
        n = $urandom_range(1, 2);
      end else begin
        unit_q.push_back($urandom_range(0, 1) ? CH_U_UP : CH_U_LO);
        n = $urandom_range(1, 4);
      end
      repeat (n) unit_q.push_back(hex_digit());
    end else if (pick < 94) begin
      n = $urandom_range(0, 4);
      unit_q.push_back(CH_LBRACE);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: c = CH_BSLASH;
          1: c = CH_LBRACE;
          2: c = 16'($urandom);
          default: c = plain_char();
        endcase
        unit_q.push_back(c);
      end
      unit_q.push_back(CH_RBRACE);
    end else if (pick < 96) begin
      // hex escape with no digit at all
      unit_q.push_back(CH_BSLASH);
      unit_q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_U_UP);
      unit_q.push_back(CH_G_LO + 16'($urandom_range(0, 19)));
    end else if (pick < 98) begin
      c = 16'($urandom);
      if ((c inside {CH_T, CH_N, CH_R, CH_QUOTE, CH_APOS, CH_LBRACE, CH_BSLASH,
                     CH_X_LO, CH_X_UP, CH_U_LO, CH_U_UP}) || (c >= CH_0 && c <= CH_7))
        c = CH_Q_LO;
      unit_q.push_back(CH_BSLASH);
      unit_q.push_back(c);
    end else begin
      unit_q.push_back($urandom_range(0, 1) ? CH_BSLASH : CH_LBRACE);
    end
  endfunction

  // Drive one code unit and hold it until the decoder takes it
  task automatic send_unit(input logic [15:0] c, input logic eos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.char_code <= c;
    chars_if.end_of_string <= eos;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    if (!sb.note_input(c, eos)) accepted_items++;
  endtask

  task automatic send_string(input bit close);
    foreach (unit_q[i]) send_unit(unit_q[i], close && (i == unit_q.size() - 1));
  endtask

  // Hold off the sender until every pending result is out
  task automatic wait_drain();
    chars_if.valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input bit en);
    cfg_if.valid <= 1'b1;
    cfg_if.interpolation_enable <= en;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.interp = en;
  endtask

  // Result side: check each beat taken, then stall at random
  initial begin
    result_t     got;
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got.kind = res_if.kind;
        got.out_char = res_if.out_char;
        got.slice_start = res_if.slice_start;
        got.slice_length = res_if.slice_length;
        got.error_code = res_if.error_code;
        sb.check_result(got, res_if.last);
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("** escape_sequence_decoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    sb = new();
    calm = 1'b0;
    accepted_items = 0;
    rst <= 1'b1;
    chars_if.valid <= 1'b0;
    chars_if.char_code <= '0;
    chars_if.end_of_string <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.interpolation_enable <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: code unit extremes, range and truncation errors
    unit_q = '{16'h0000, 16'hFFFF, CH_BSLASH, CH_N};
    send_string(1'b1);
    unit_q = '{CH_BSLASH, CH_7, CH_7, CH_7};
    send_string(1'b1);
    unit_q = '{CH_BSLASH, CH_X_UP, CH_A_LO, CH_G_UP};
    send_string(1'b1);
    unit_q = '{CH_BSLASH, CH_U_LO, CH_0 + 16'd1};
    send_string(1'b1);
    unit_q = '{CH_BSLASH};
    send_string(1'b1);
    unit_q = '{CH_BSLASH, 16'h00E9, CH_A_LO};
    send_string(1'b1);
    unit_q = '{CH_BSLASH, CH_X_LO, CH_G_LO};
    send_string(1'b1);

    // Directed: octal ended by an opening brace, then a brace that outlives a config change
    wait_drain();
    write_cfg(1'b1);
    unit_q = '{CH_BSLASH, CH_0 + 16'd1, CH_LBRACE};
    send_string(1'b1);
    unit_q = '{CH_LBRACE, CH_A_LO};
    send_string(1'b0);
    wait_drain();
    write_cfg(1'b0);
    send_unit(CH_RBRACE, 1'b1);

    // Random literals in four phases of the interpolation setting
    for (int p = 0; p < 4; p++) begin
      wait_drain();
      write_cfg((p == 3) ? 1'($urandom_range(0, 1)) : ((p % 2) == 0));
      target = accepted_items + RANDOM_ITEMS / 4;
      while (accepted_items < target) begin
        calm = ($urandom_range(0, 5) == 0);
        unit_q.delete();
        repeat ($urandom_range(1, 4)) add_token();
        send_string(1'b1);
        if ($urandom_range(0, 7) == 0) wait_drain();
      end
    end
    calm = 1'b0;

    chars_if.valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("** escape_sequence_decoder: PASSED **");
    end else begin
      $display("** escape_sequence_decoder: FAILED **");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/esd_pkg.sv
hw/rtl/esd_in_if.sv
hw/rtl/esd_out_if.sv
hw/rtl/esd_cfg_if.sv
hw/rtl/esd_front.sv
hw/rtl/esd_queue.sv
hw/rtl/esd_back.sv
hw/rtl/escape_sequence_decoder.sv
tb/tb.sv
